// ===== rtl/cia_pkg.sv =====
// Shared types, constants and widths for the complex integer ALU.
package cia_pkg;
    localparam int OpW = 16;
    localparam int ProdW = 2 * OpW + 1;
    localparam int ResW = 32;
    localparam int QW = ProdW;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef struct packed {
        logic            v;
        t_mode           mode;
        logic            dz;
        logic            nr;
        logic            ni;
        logic [QW-1:0]   rem_r;
        logic [QW-1:0]   rem_i;
        logic [QW-1:0]   q_r;
        logic [QW-1:0]   q_i;
        logic [QW-1:0]   den;
        logic [ResW-1:0] sres_r;
        logic [ResW-1:0] sres_i;
    } t_dstage;
endpackage

// ===== rtl/complex_integer_alu_core.sv =====
// Top level of the pipelined complex integer ALU with restoring divider.
//
// One request channel carries a mode and two complex operands with signed
// 16-bit parts; one result channel returns the 32-bit real and imaginary
// parts and a divide-by-zero flag. Both channels use valid and stall.
// Add and subtract are part by part, multiply is the complex product and
// divide gives C-style truncated quotients over br*br+bi*bi. A zero
// denominator in divide mode gives zero parts and sets the flag.
//
// Every request runs through the same pipeline: an input register, a
// product stage, one setup stage, one stage per quotient bit of the
// restoring divider (33 stages) and a sign fix stage into the output
// register. A new request is taken in every cycle unless a valid result
// is stalled, so the throughput is one request per cycle without stalls.
//
// Reset clears all valid bits; the pipeline then holds no request.
// When the receiver stalls a valid result, the whole pipeline holds and
// the input channel is stalled in the same cycle, so no request is lost
// or repeated.
module complex_integer_alu_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_mode,
    input  logic signed [15:0]          i_a_real,
    input  logic signed [15:0]          i_a_imag,
    input  logic signed [15:0]          i_b_real,
    input  logic signed [15:0]          i_b_imag,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_res_real,
    output logic signed [31:0]          o_res_imag,
    output logic                        o_div_zero
);
    import cia_pkg::*;

    localparam int NSt = QW;

    logic                     adv;

    logic                     r_v1;
    t_mode                    r_mode1;
    logic signed [OpW-1:0]    r_ar1, r_ai1, r_br1, r_bi1;

    logic                     r_v2;
    t_mode                    r_mode2;
    logic signed [ProdW-1:0]  r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_dd;
    logic signed [OpW:0]      r_s_r, r_s_i;

    t_dstage                  r_d [0:NSt];
    t_dstage                  n_d [0:NSt];
    t_dstage                  n_d0;

    logic                     r_ov;
    logic [ResW-1:0]          r_or, r_oi;
    logic                     r_oz;

    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (adv) begin
            r_mode1 <= t_mode'(i_mode);
            r_ar1 <= i_a_real;
            r_ai1 <= i_a_imag;
            r_br1 <= i_b_real;
            r_bi1 <= i_b_imag;
            r_mode2 <= r_mode1;
            r_p_rr <= ProdW'(r_ar1 * r_br1);
            r_p_ii <= ProdW'(r_ai1 * r_bi1);
            r_p_ri <= ProdW'(r_ar1 * r_bi1);
            r_p_ir <= ProdW'(r_ai1 * r_br1);
            r_p_bb <= ProdW'(r_br1 * r_br1);
            r_p_dd <= ProdW'(r_bi1 * r_bi1);
            r_s_r <= (r_mode1 == MODE_SUB) ? (OpW+1)'(r_ar1 - r_br1)
                                           : (OpW+1)'(r_ar1 + r_br1);
            r_s_i <= (r_mode1 == MODE_SUB) ? (OpW+1)'(r_ai1 - r_bi1)
                                           : (OpW+1)'(r_ai1 + r_bi1);
        end
    end

    always_comb begin
        logic signed [ProdW:0] num_r, num_i, den;
        logic [ProdW:0]        abs_r, abs_i;
        num_r = {1'b0, ProdW'(0)};
        num_i = {1'b0, ProdW'(0)};
        den = (ProdW+1)'(r_p_bb) + (ProdW+1)'(r_p_dd);
        abs_r = '0;
        abs_i = '0;
        n_d0 = '0;
        n_d0.v = r_v2;
        n_d0.mode = r_mode2;
        n_d0.den = QW'(den);
        n_d0.dz = (r_mode2 == MODE_DIV) && (den == '0);
        case (r_mode2)
            MODE_ADD, MODE_SUB: begin
                n_d0.sres_r = ResW'(r_s_r);
                n_d0.sres_i = ResW'(r_s_i);
            end
            MODE_MUL: begin
                n_d0.sres_r = ResW'((ProdW+1)'(r_p_rr) - (ProdW+1)'(r_p_ii));
                n_d0.sres_i = ResW'((ProdW+1)'(r_p_ri) + (ProdW+1)'(r_p_ir));
            end
            default: begin
                num_r = (ProdW+1)'(r_p_rr) + (ProdW+1)'(r_p_ii);
                num_i = (ProdW+1)'(r_p_ir) - (ProdW+1)'(r_p_ri);
            end
        endcase
        abs_r = num_r[ProdW] ? (ProdW+1)'(-num_r) : num_r;
        abs_i = num_i[ProdW] ? (ProdW+1)'(-num_i) : num_i;
        n_d0.nr = num_r[ProdW];
        n_d0.ni = num_i[ProdW];
        n_d0.q_r = QW'(abs_r);
        n_d0.q_i = QW'(abs_i);
    end

    // Each stage moves one dividend bit into the remainder and takes one quotient bit.
    always_comb begin
        logic [QW:0] tr, ti;
        n_d[0] = n_d0;
        for (int k = 1; k <= NSt; k++) begin
            n_d[k] = r_d[k-1];
            tr = {r_d[k-1].rem_r, r_d[k-1].q_r[QW-1]};
            ti = {r_d[k-1].rem_i, r_d[k-1].q_i[QW-1]};
            n_d[k].q_r = {r_d[k-1].q_r[QW-2:0], 1'b0};
            n_d[k].q_i = {r_d[k-1].q_i[QW-2:0], 1'b0};
            if (tr >= {1'b0, r_d[k-1].den}) begin
                tr = tr - {1'b0, r_d[k-1].den};
                n_d[k].q_r[0] = 1'b1;
            end
            if (ti >= {1'b0, r_d[k-1].den}) begin
                ti = ti - {1'b0, r_d[k-1].den};
                n_d[k].q_i[0] = 1'b1;
            end
            n_d[k].rem_r = QW'(tr);
            n_d[k].rem_i = QW'(ti);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= NSt; k++) begin
            if (!i_rst_n) begin
                r_d[k].v <= 1'b0;
            end else if (adv) begin
                r_d[k] <= n_d[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_d[NSt].v;
        end
        if (adv) begin
            r_oz <= r_d[NSt].dz;
            if (r_d[NSt].mode != MODE_DIV) begin
                r_or <= r_d[NSt].sres_r;
                r_oi <= r_d[NSt].sres_i;
            end else if (r_d[NSt].dz) begin
                r_or <= '0;
                r_oi <= '0;
            end else begin
                r_or <= r_d[NSt].nr ? ResW'(-r_d[NSt].q_r) : ResW'(r_d[NSt].q_r);
                r_oi <= r_d[NSt].ni ? ResW'(-r_d[NSt].q_i) : ResW'(r_d[NSt].q_i);
            end
        end
    end

    assign o_valid = r_ov;
    assign o_res_real = r_or;
    assign o_res_imag = r_oi;
    assign o_div_zero = r_oz;
endmodule

// ===== rtl/cia_checker.sv =====
// Port-level checker for the complex integer ALU and its bind statement.
module cia_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_res_real,
    input logic [31:0] o_res_imag,
    input logic        o_div_zero
);
    a_zero_parts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_real == 32'd0 && o_res_imag == 32'd0)
        else $error("divide by zero with nonzero parts");
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res_real) && $stable(o_res_imag))
        else $error("stalled result changed");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind complex_integer_alu_core cia_checker u_cia_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for the complex integer ALU core with random idling and stalls.
module tb_top;
    import cia_pkg::*;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               dz;
    } t_cplx_res;

    class cplx_scoreboard;
        t_cplx_res pending[$];
        int        mismatches;

        function t_cplx_res compute(t_mode mode, logic signed [15:0] ar,
                                    logic signed [15:0] ai, logic signed [15:0] br,
                                    logic signed [15:0] bi);
            t_cplx_res r;
            longint xr;
            longint xi;
            longint yr;
            longint yi;
            longint den;
            longint re;
            longint im;
            xr = ar;
            xi = ai;
            yr = br;
            yi = bi;
            re = 0;
            im = 0;
            r.dz = 1'b0;
            case (mode)
                MODE_ADD: begin
                    re = xr + yr;
                    im = xi + yi;
                end
                MODE_SUB: begin
                    re = xr - yr;
                    im = xi - yi;
                end
                MODE_MUL: begin
                    re = xr * yr - xi * yi;
                    im = xr * yi + xi * yr;
                end
                default: begin
                    den = yr * yr + yi * yi;
                    if (den == 0) begin
                        r.dz = 1'b1;
                    end else begin
                        re = (xr * yr + xi * yi) / den;
                        im = (xi * yr - xr * yi) / den;
                    end
                end
            endcase
            r.re = re[31:0];
            r.im = im[31:0];
            return r;
        endfunction

        function void note_request(t_mode mode, logic signed [15:0] ar,
                                   logic signed [15:0] ai, logic signed [15:0] br,
                                   logic signed [15:0] bi);
            pending.push_back(compute(mode, ar, ai, br, bi));
        endfunction

        function void check_result(logic signed [31:0] re, logic signed [31:0] im,
                                   logic dz);
            t_cplx_res e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result re=%0d im=%0d dz=%0b", re, im, dz);
                end
                return;
            end
            e = pending.pop_front();
            if (e.re !== re || e.im !== im || e.dz !== dz) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected re=%0d im=%0d dz=%0b, got re=%0d im=%0d dz=%0b",
                             e.re, e.im, e.dz, re, im, dz);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_mode = 2'd0;
    logic signed [15:0] i_a_real = '0;
    logic signed [15:0] i_a_imag = '0;
    logic signed [15:0] i_b_real = '0;
    logic signed [15:0] i_b_imag = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [31:0] o_res_real;
    logic signed [31:0] o_res_imag;
    logic               o_div_zero;

    cplx_scoreboard sb = new();
    bit             quiet_tail = 1'b0;
    bit             hold_off = 1'b0;
    bit             stim_done = 1'b0;

    always #10 i_clk = ~i_clk;

    complex_integer_alu_core u_dut (.*);

    task automatic send_request(t_mode mode, logic [15:0] ar, logic [15:0] ai,
                                logic [15:0] br, logic [15:0] bi);
        i_valid  <= 1'b1;
        i_mode   <= mode;
        i_a_real <= ar;
        i_a_imag <= ai;
        i_b_real <= br;
        i_b_imag <= bi;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(mode, ar, ai, br, bi);
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [15:0] edge_vals[6];
        logic [15:0] br;
        logic [15:0] bi;
        t_mode       m;
        edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h5a5a};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            send_request(t_mode'(k), 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
            send_request(t_mode'(k), 16'h7fff, 16'h8000, 16'h7fff, 16'h0001);
        end
        send_request(MODE_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
        send_request(MODE_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000);
        send_request(MODE_DIV, 16'h8000, 16'h0000, 16'hffff, 16'h0000);
        send_request(MODE_DIV, 16'h0007, 16'hfff9, 16'h0002, 16'h0001);
        send_request(MODE_DIV, 16'hfff9, 16'h0007, 16'hfffe, 16'h0003);
        for (int k = 0; k < 6; k++) begin
            send_request(MODE_MUL, edge_vals[k], edge_vals[5 - k], edge_vals[k], edge_vals[k]);
        end
        for (int n = 0; n < 1550; n++) begin
            if (n == 1300) quiet_tail = 1'b1;
            if (n == 200) hold_off = 1'b1;
            sender_gap();
            m = t_mode'($urandom_range(0, 3));
            br = pick_operand();
            bi = pick_operand();
            if (m == MODE_DIV && $urandom_range(0, 19) == 0) begin
                br = '0;
                bi = '0;
            end
            send_request(m, pick_operand(), pick_operand(), br, bi);
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin : receiver
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                i_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end else begin
                n = quiet_tail ? 1 : $urandom_range(1, 20);
                i_stall <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_res_real, o_res_imag, o_div_zero);
        end
    end

    initial begin : finisher
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS complex_integer_alu_core");
        end else begin
            $display("FAIL complex_integer_alu_core");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("FAIL complex_integer_alu_core");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/cia_pkg.sv
rtl/complex_integer_alu_core.sv
rtl/cia_checker.sv
test/tb_top.sv
